// ===== hw/rtl/qdd_pkg.sv =====
package qdd_pkg;

  // default counter width
  localparam int unsigned COUNT_WIDTH_DEF = 32;

  // register defaults
  localparam logic [3:0] SPD_RESET = 4'd4;
  localparam logic       REV_RESET = 1'b0;

  // register indexes, decoded from paddr[2]
  localparam logic REG_SPD = 1'b0;
  localparam logic REG_REV = 1'b1;

  // request kinds
  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_READ   = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_START  = 2'd3
  } qdd_kind_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } qdd_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic apply;       // sample, clear or start request taken
    logic div_load;    // read request taken, set up the divider
    logic div_step;    // one quotient bit
    logic div_commit;  // write back remainder, publish quotient
  } qdd_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic div_last;
  } qdd_stat_t;

  // x4 transition table, index {prev_a, prev_b, cur_a, cur_b}
  function automatic logic signed [1:0] step_lut(input logic [3:0] idx);
    logic signed [1:0] d;
    unique case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: d = -2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: d = 2'sd1;
      default:                 d = 2'sd0;
    endcase
    return d;
  endfunction

endpackage

// ===== hw/rtl/qdd_ctrl.sv =====
module qdd_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [1:0]       in_kind,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  qdd_pkg::qdd_stat_t stat,
  output qdd_pkg::qdd_cmd_t  cmd
);

  qdd_pkg::qdd_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;
  logic accept;
  logic is_read;

  // output register free when empty or being drained this cycle
  assign out_free = !out_valid_r || out_ready;
  assign is_read  = (in_kind == qdd_pkg::KIND_READ);
  assign accept   = in_valid && in_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      qdd_pkg::ST_IDLE: begin
        if (accept && is_read) state_nxt = qdd_pkg::ST_DIV;
      end
      qdd_pkg::ST_DIV: begin
        if (stat.div_last) state_nxt = qdd_pkg::ST_DONE;
      end
      qdd_pkg::ST_DONE: begin
        if (out_free) state_nxt = qdd_pkg::ST_IDLE;
      end
      default: state_nxt = qdd_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready       = (state_r == qdd_pkg::ST_IDLE) && out_free;
    cmd.apply      = in_valid && in_ready && !is_read;
    cmd.div_load   = in_valid && in_ready && is_read;
    cmd.div_step   = (state_r == qdd_pkg::ST_DIV);
    cmd.div_commit = (state_r == qdd_pkg::ST_DONE) && out_free;
  end

  // result valid flag
  always_comb begin
    if (cmd.apply || cmd.div_commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= qdd_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== hw/rtl/qdd_dp.sv =====
module qdd_dp #(
  parameter int unsigned COUNT_WIDTH = qdd_pkg::COUNT_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  qdd_pkg::qdd_cmd_t        cmd,
  output qdd_pkg::qdd_stat_t       stat,
  input  logic [1:0]               in_kind,
  input  logic                     in_phase_a,
  input  logic                     in_phase_b,
  input  logic [3:0]               spd,
  input  logic                     rev,
  output logic [COUNT_WIDTH-1:0]   det_o,
  output logic [COUNT_WIDTH-1:0]   raw_o,
  output logic [COUNT_WIDTH-1:0]   inv_o,
  output logic [COUNT_WIDTH-1:0]   pend_o
);

  localparam int unsigned CW    = COUNT_WIDTH;
  localparam int unsigned CNT_W = (CW > 1) ? $clog2(CW) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CW - 1);

  // counters
  logic [1:0]    prev_r, prev_nxt;
  logic [CW-1:0] pend_r, pend_nxt;
  logic [CW-1:0] raw_r, raw_nxt;
  logic [CW-1:0] inv_r, inv_nxt;

  // divider
  logic [CW-1:0]    quot_r, quot_nxt;
  logic [3:0]       rem_r, rem_nxt;
  logic [3:0]       div_s_r, div_s_nxt;
  logic             neg_r, neg_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // result register
  logic [CW-1:0] det_out_r, det_out_nxt;
  logic [CW-1:0] raw_out_r, raw_out_nxt;
  logic [CW-1:0] inv_out_r, inv_out_nxt;
  logic [CW-1:0] pend_out_r, pend_out_nxt;

  logic [1:0]        cur;
  logic signed [1:0] step_raw;
  logic signed [1:0] step;
  logic [CW-1:0]     step_ext;
  logic [4:0]        trial;
  logic [4:0]        trial_sub;
  logic              trial_ge;
  logic [CW-1:0]     mag;
  logic [CW-1:0]     q_fin;
  logic [CW-1:0]     r_ext;
  logic [CW-1:0]     r_fin;

  // step decode
  assign cur      = {in_phase_a, in_phase_b};
  assign step_raw = qdd_pkg::step_lut({prev_r, cur});
  assign step     = rev ? -step_raw : step_raw;
  assign step_ext = {{(CW-2){step[1]}}, step};

  // restoring division, one quotient bit per cycle
  assign trial     = {rem_r, quot_r[CW-1]};
  assign trial_ge  = (trial >= {1'b0, div_s_r});
  assign trial_sub = trial - {1'b0, div_s_r};
  assign mag       = pend_r[CW-1] ? (~pend_r + 1'b1) : pend_r;
  assign q_fin     = neg_r ? (~quot_r + 1'b1) : quot_r;
  assign r_ext     = {{(CW-4){1'b0}}, rem_r};
  assign r_fin     = neg_r ? (~r_ext + 1'b1) : r_ext;

  assign stat.div_last = cmd.div_step && (cnt_r == CNT_LAST);

  // counter update
  always_comb begin
    prev_nxt = prev_r;
    pend_nxt = pend_r;
    raw_nxt  = raw_r;
    inv_nxt  = inv_r;
    if (cmd.apply) begin
      unique case (in_kind)
        qdd_pkg::KIND_SAMPLE: begin
          if ((prev_r ^ cur) == 2'b11) begin
            inv_nxt = inv_r + 1'b1;
          end else begin
            pend_nxt = pend_r + step_ext;
            raw_nxt  = raw_r + step_ext;
          end
          prev_nxt = cur;
        end
        qdd_pkg::KIND_CLEAR: begin
          pend_nxt = '0;
          raw_nxt  = '0;
          inv_nxt  = '0;
        end
        qdd_pkg::KIND_START: begin
          prev_nxt = cur;
          pend_nxt = '0;
          raw_nxt  = '0;
          inv_nxt  = '0;
        end
        default: begin
          prev_nxt = prev_r;
        end
      endcase
    end else if (cmd.div_commit) begin
      pend_nxt = r_fin;
    end
  end

  // divider update
  always_comb begin
    quot_nxt  = quot_r;
    rem_nxt   = rem_r;
    div_s_nxt = div_s_r;
    neg_nxt   = neg_r;
    cnt_nxt   = cnt_r;
    if (cmd.div_load) begin
      quot_nxt  = mag;
      rem_nxt   = '0;
      div_s_nxt = (spd == 4'd0) ? 4'd1 : spd;
      neg_nxt   = pend_r[CW-1];
      cnt_nxt   = '0;
    end else if (cmd.div_step) begin
      quot_nxt = {quot_r[CW-2:0], trial_ge};
      rem_nxt  = trial_ge ? trial_sub[3:0] : trial[3:0];
      cnt_nxt  = cnt_r + 1'b1;
    end
  end

  // result register load
  always_comb begin
    det_out_nxt  = det_out_r;
    raw_out_nxt  = raw_out_r;
    inv_out_nxt  = inv_out_r;
    pend_out_nxt = pend_out_r;
    if (cmd.apply || cmd.div_commit) begin
      det_out_nxt  = cmd.div_commit ? q_fin : '0;
      raw_out_nxt  = raw_nxt;
      inv_out_nxt  = inv_nxt;
      pend_out_nxt = pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      pend_r <= '0;
      raw_r  <= '0;
      inv_r  <= '0;
      cnt_r  <= '0;
    end else begin
      prev_r <= prev_nxt;
      pend_r <= pend_nxt;
      raw_r  <= raw_nxt;
      inv_r  <= inv_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quot_r     <= quot_nxt;
    rem_r      <= rem_nxt;
    div_s_r    <= div_s_nxt;
    neg_r      <= neg_nxt;
    det_out_r  <= det_out_nxt;
    raw_out_r  <= raw_out_nxt;
    inv_out_r  <= inv_out_nxt;
    pend_out_r <= pend_out_nxt;
  end

  assign det_o  = det_out_r;
  assign raw_o  = raw_out_r;
  assign inv_o  = inv_out_r;
  assign pend_o = pend_out_r;

endmodule

// ===== hw/rtl/quadrature_detent_decoder_top.sv =====
// Quadrature x4 decoder that turns phase A/B samples into signed steps and
// gathers them into whole detents. Every request gives exactly one result.
// Pin sample, clear and start requests never enter the divider, so samples
// can stream at one per cycle while the result side keeps up. A read
// request runs a restoring divider that produces one quotient bit per
// cycle, and the input is held off from the read until the quotient is
// published. Registers (APB, byte address 4*i): 0 steps per detent (4
// bits, 0 acts as 1), 1 reverse direction. Write them only while no
// request is in flight. Counters are COUNT_WIDTH bits wide and wrap; the
// 32-bit result fields are sign- or zero-extended or cut from them.
module quadrature_detent_decoder_top #(
  parameter int unsigned COUNT_WIDTH = qdd_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic        in_phase_a,
  input  logic        in_phase_b,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] out_detents,
  output logic signed [31:0] out_raw_steps,
  output logic [31:0] out_invalid_count,
  output logic signed [31:0] out_pending_remainder,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CW = COUNT_WIDTH;

  logic [3:0] spd_r, spd_nxt;
  logic       rev_r, rev_nxt;
  logic       cfg_wr;

  qdd_pkg::qdd_cmd_t  cmd;
  qdd_pkg::qdd_stat_t stat;

  logic [CW-1:0] det_w, raw_w, inv_w, pend_w;

  // register writes
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    spd_nxt = spd_r;
    rev_nxt = rev_r;
    if (cfg_wr) begin
      unique case (paddr[2])
        qdd_pkg::REG_SPD: spd_nxt = pwdata[3:0];
        qdd_pkg::REG_REV: rev_nxt = pwdata[0];
        default:          spd_nxt = spd_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spd_r <= qdd_pkg::SPD_RESET;
      rev_r <= qdd_pkg::REV_RESET;
    end else begin
      spd_r <= spd_nxt;
      rev_r <= rev_nxt;
    end
  end

  // register reads
  always_comb begin
    unique case (paddr[2])
      qdd_pkg::REG_SPD: prdata = {28'd0, spd_r};
      qdd_pkg::REG_REV: prdata = {31'd0, rev_r};
      default:          prdata = '0;
    endcase
  end

  qdd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  qdd_dp #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_kind    (in_kind),
    .in_phase_a (in_phase_a),
    .in_phase_b (in_phase_b),
    .spd        (spd_r),
    .rev        (rev_r),
    .det_o      (det_w),
    .raw_o      (raw_w),
    .inv_o      (inv_w),
    .pend_o     (pend_w)
  );

  // fit counter width to the 32-bit result fields
  generate
    if (CW >= 32) begin : g_cut
      assign out_detents           = det_w[31:0];
      assign out_raw_steps         = raw_w[31:0];
      assign out_invalid_count     = inv_w[31:0];
      assign out_pending_remainder = pend_w[31:0];
    end else begin : g_ext
      assign out_detents           = {{(32-CW){det_w[CW-1]}}, det_w};
      assign out_raw_steps         = {{(32-CW){raw_w[CW-1]}}, raw_w};
      assign out_invalid_count     = {{(32-CW){1'b0}}, inv_w};
      assign out_pending_remainder = {{(32-CW){pend_w[CW-1]}}, pend_w};
    end
  endgenerate

endmodule

// ===== hw/rtl/qdd_checker.sv =====
module qdd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_kind,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_detents,
  input logic [31:0] out_raw_steps,
  input logic [31:0] out_invalid_count,
  input logic [31:0] out_pending_remainder
);

  logic take;
  assign take = in_valid && in_ready;

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_raw_steps)
      && $stable(out_pending_remainder) && $stable(out_detents))
    else $error("result changed while stalled");

  // non-read requests give a result next cycle with no detents
  a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
    take && in_kind != qdd_pkg::KIND_READ |=> out_valid && out_detents == 32'd0)
    else $error("non-read request gave no immediate zero-detent result");

  // clear and start leave all counters at zero
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    take && (in_kind == qdd_pkg::KIND_CLEAR || in_kind == qdd_pkg::KIND_START)
      |=> out_raw_steps == 32'd0 && out_invalid_count == 32'd0
        && out_pending_remainder == 32'd0)
    else $error("counters not cleared");

  // the divider blocks new requests once a read is taken
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    take && in_kind == qdd_pkg::KIND_READ |=> !in_ready)
    else $error("request taken during division");

endmodule

bind quadrature_detent_decoder_top qdd_checker u_qdd_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_valid              (in_valid),
  .in_ready              (in_ready),
  .in_kind               (in_kind),
  .out_valid             (out_valid),
  .out_ready             (out_ready),
  .out_detents           (out_detents),
  .out_raw_steps         (out_raw_steps),
  .out_invalid_count     (out_invalid_count),
  .out_pending_remainder (out_pending_remainder)
);
